// ----- sv/bmm_pkg.sv -----
`default_nettype none
package bmm_pkg;

    localparam int NUM_LEFT  = 64;
    localparam int NUM_RIGHT = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_LD_RD = 14'b00000000000010,
        ST_LD_WR = 14'b00000000000100,
        ST_MINIT = 14'b00000000001000,
        ST_ROOT  = 14'b00000000010000,
        ST_POP   = 14'b00000000100000,
        ST_FETCH = 14'b00000001000000,
        ST_SCAN0 = 14'b00000010000000,
        ST_SCAN  = 14'b00000100000000,
        ST_ENQ   = 14'b00001000000000,
        ST_AUG1  = 14'b00010000000000,
        ST_AUG2  = 14'b00100000000000,
        ST_AUG3  = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } bmm_state_t;

    typedef struct packed {
        logic accept;
        logic load_rd;
        logic load_wr;
        logic init;
        logic root_start;
        logic pop_rd;
        logic fetch;
        logic scan_load;
        logic scan_step;
        logic enq;
        logic aug1;
        logic aug2;
        logic aug3;
        logic next_root;
        logic out_load;
    } bmm_cmd_t;

    typedef struct packed {
        logic last;
        logic root_eq_n;
        logic queue_empty;
        logic cand_zero;
        logic v_free;
        logic aug_done;
        logic out_busy;
    } bmm_stat_t;

endpackage
`default_nettype wire

// ----- sv/bmm_if.sv -----
`default_nettype none
interface bmm_edge_if;
    logic       valid;
    logic       ready;
    logic [5:0] left_index;
    logic [5:0] right_index;
    logic       edge_present;
    logic       last_edge;
    modport source (output valid, left_index, right_index, edge_present, last_edge,
                    input ready);
    modport sink   (input valid, left_index, right_index, edge_present, last_edge,
                    output ready);
endinterface

interface bmm_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] matching_size;
    modport source (output valid, matching_size, input ready);
    modport sink   (input valid, matching_size, output ready);
endinterface

interface bmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] left_count;
    modport source (output valid, left_count, input ready);
    modport sink   (input valid, left_count, output ready);
endinterface
`default_nettype wire

// ----- sv/bmm_ram.sv -----
`default_nettype none
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- sv/bmm_ctrl.sv -----
`default_nettype none
module bmm_ctrl
    import bmm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      out_ready,
    input  wire bmm_stat_t stat,
    output logic           in_ready,
    output bmm_cmd_t       cmd
);
    bmm_state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                cmd.load_rd = 1'b1;
                state_next  = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next  = stat.last ? ST_MINIT : ST_IDLE;
            end
            ST_MINIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (stat.root_eq_n)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.root_start = 1'b1;
                    state_next     = ST_POP;
                end
            end
            ST_POP:
            begin
                if (stat.queue_empty)
                begin
                    cmd.next_root = 1'b1;
                    state_next    = ST_ROOT;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SCAN0;
            end
            ST_SCAN0:
            begin
                cmd.scan_load = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.cand_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = stat.v_free ? ST_AUG1 : ST_ENQ;
                end
            end
            ST_ENQ:
            begin
                cmd.enq    = 1'b1;
                state_next = ST_SCAN;
            end
            ST_AUG1:
            begin
                cmd.aug1   = 1'b1;
                state_next = ST_AUG2;
            end
            ST_AUG2:
            begin
                cmd.aug2   = 1'b1;
                state_next = ST_AUG3;
            end
            ST_AUG3:
            begin
                cmd.aug3 = 1'b1;
                if (stat.aug_done)
                begin
                    cmd.next_root = 1'b1;
                    state_next    = ST_ROOT;
                end
                else
                begin
                    state_next = ST_AUG1;
                end
            end
            ST_OUT:
            begin
                if (!stat.out_busy || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/bmm_dpath.sv -----
`default_nettype none
module bmm_dpath
    import bmm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bmm_cmd_t         cmd,
    input  wire logic [IDX_W-1:0] left_index,
    input  wire logic [IDX_W-1:0] right_index,
    input  wire logic             edge_present,
    input  wire logic             last_edge,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic      [CNT_W-1:0] out_size,
    output bmm_stat_t             stat
);
    logic [IDX_W-1:0]     lidx_reg, ridx_reg;
    logic                 present_reg, last_reg;
    logic [CNT_W-1:0]     left_count_reg;
    logic                 graph_open_reg;
    logic [NUM_LEFT-1:0]  row_valid_reg;
    logic [NUM_RIGHT-1:0] rm_valid_reg;
    logic [NUM_RIGHT-1:0] visited_reg;
    logic [NUM_RIGHT-1:0] cand_reg;
    logic [IDX_W-1:0]     cur_u_reg, cur_v_reg, aug_u_reg;
    logic [CNT_W-1:0]     root_reg, n_reg, count_reg, head_reg, tail_reg;
    logic                 out_valid_reg;
    logic [CNT_W-1:0]     out_size_reg;

    logic [NUM_RIGHT-1:0] adj_rdata, adj_wdata, cand;
    logic [IDX_W-1:0]     adj_raddr, q_rdata, par_rdata, rm_rdata, lm_rdata, v_sel;
    logic [IDX_W-1:0]     q_waddr, q_wdata;

    // lowest pending right vertex
    always_comb
    begin
        cand  = cand_reg & ~visited_reg;
        v_sel = '0;
        for (int i = NUM_RIGHT - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                v_sel = IDX_W'(i);
            end
        end
    end

    assign adj_raddr = cmd.load_rd ? lidx_reg : q_rdata;
    assign adj_wdata = (row_valid_reg[lidx_reg] ? adj_rdata : '0)
                     | (NUM_RIGHT'(1) << ridx_reg);
    assign q_waddr   = cmd.root_start ? '0 : tail_reg[IDX_W-1:0];
    assign q_wdata   = cmd.root_start ? root_reg[IDX_W-1:0] : rm_rdata;

    bmm_ram #(.WIDTH(NUM_RIGHT), .DEPTH(NUM_LEFT)) u_adj (
        .clk(clk), .we(cmd.load_wr && present_reg), .waddr(lidx_reg), .wdata(adj_wdata),
        .re(cmd.load_rd || cmd.fetch), .raddr(adj_raddr), .rdata(adj_rdata)
    );
    bmm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_LEFT)) u_queue (
        .clk(clk), .we(cmd.root_start || cmd.enq), .waddr(q_waddr), .wdata(q_wdata),
        .re(cmd.pop_rd), .raddr(head_reg[IDX_W-1:0]), .rdata(q_rdata)
    );
    bmm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_RIGHT)) u_par (
        .clk(clk), .we(cmd.scan_step), .waddr(v_sel), .wdata(cur_u_reg),
        .re(cmd.aug1), .raddr(cur_v_reg), .rdata(par_rdata)
    );
    bmm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_RIGHT)) u_rmate (
        .clk(clk), .we(cmd.aug2), .waddr(cur_v_reg), .wdata(par_rdata),
        .re(cmd.scan_step), .raddr(v_sel), .rdata(rm_rdata)
    );
    bmm_ram #(.WIDTH(IDX_W), .DEPTH(NUM_LEFT)) u_lmate (
        .clk(clk), .we(cmd.aug3), .waddr(aug_u_reg), .wdata(cur_v_reg),
        .re(cmd.aug2), .raddr(par_rdata), .rdata(lm_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lidx_reg    <= left_index;
            ridx_reg    <= right_index;
            present_reg <= edge_present;
            last_reg    <= last_edge;
        end
        if (cmd.scan_load)
        begin
            cand_reg <= row_valid_reg[cur_u_reg] ? adj_rdata : '0;
        end
        if (cmd.fetch)
        begin
            cur_u_reg <= q_rdata;
        end
        if (cmd.scan_step)
        begin
            cur_v_reg <= v_sel;
        end
        else if (cmd.aug3)
        begin
            cur_v_reg <= lm_rdata;
        end
        if (cmd.aug2)
        begin
            aug_u_reg <= par_rdata;
        end
        if (cmd.init)
        begin
            n_reg <= (left_count_reg > CNT_W'(NUM_LEFT)) ? CNT_W'(NUM_LEFT) : left_count_reg;
        end
        if (cmd.out_load)
        begin
            out_size_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg <= CNT_W'(NUM_LEFT);
            graph_open_reg <= 1'b0;
            row_valid_reg  <= '0;
            rm_valid_reg   <= '0;
            visited_reg    <= '0;
            root_reg       <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                left_count_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                graph_open_reg <= 1'b1;
                if (!graph_open_reg)
                begin
                    row_valid_reg <= '0;
                end
            end
            if (cmd.load_wr && present_reg)
            begin
                row_valid_reg[lidx_reg] <= 1'b1;
            end
            if (cmd.init)
            begin
                rm_valid_reg <= '0;
                root_reg     <= '0;
                count_reg    <= '0;
            end
            if (cmd.root_start)
            begin
                visited_reg <= '0;
                head_reg    <= '0;
                tail_reg    <= CNT_W'(1);
            end
            if (cmd.fetch)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                visited_reg[v_sel] <= 1'b1;
            end
            if (cmd.enq)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (cmd.aug2)
            begin
                rm_valid_reg[cur_v_reg] <= 1'b1;
            end
            if (cmd.aug3 && stat.aug_done)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.next_root)
            begin
                root_reg <= root_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                graph_open_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last        = last_reg;
    assign stat.root_eq_n   = (root_reg == n_reg);
    assign stat.queue_empty = (head_reg == tail_reg);
    assign stat.cand_zero   = (cand == '0);
    assign stat.v_free      = !rm_valid_reg[v_sel];
    assign stat.aug_done    = (aug_u_reg == root_reg[IDX_W-1:0]);
    assign stat.out_busy    = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_size  = out_size_reg;
endmodule
`default_nettype wire

// ----- sv/bipartite_max_matching_top.sv -----
// Bipartite maximum matching engine.
// src: one edge per transfer (left_index, right_index, edge_present, last_edge).
//   The first transfer after reset or after a finished graph starts a new,
//   empty graph. Each edge transfer runs through accept, row read and row
//   write: the adjacency rows live in a single-port-per-side RAM, so every
//   present edge is a read-modify-write of its row.
// last_edge = 1 closes the graph and starts the search; one matching_size
//   transfer appears on dst, nothing for other edges.
// Search: one augmenting-path search (breadth-first over alternating paths)
//   per left vertex below left_count (clamped to 64). Each search dequeues
//   left vertices (pop, fetch, row load), steps through the unvisited right
//   vertices of each row (enqueueing the mate of a matched one) and walks a
//   found path back to its root (parent read, right-mate and left-mate write).
// cfg: writes left_count; always ready. Write only while idle.
// Reset: left_count = 64, graph empty, no result pending. The adjacency RAM
//   is not cleared; per-row valid flops mark rows written in this graph.
// dst stall: the result register holds until taken; src stays open, but a
//   further graph cannot deliver its result until the held one is taken.
`default_nettype none
module bipartite_max_matching_top
    import bmm_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    bmm_edge_if.sink   src,
    bmm_result_if.source dst,
    bmm_cfg_if.sink    cfg
);
    bmm_cmd_t  cmd;
    bmm_stat_t stat;

    assign cfg.ready = 1'b1;

    // sequencer
    bmm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(src.valid), .out_ready(dst.ready),
        .stat(stat), .in_ready(src.ready), .cmd(cmd)
    );

    // RAMs, queue pointers, mate valid bits, result register
    bmm_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .left_index(src.left_index), .right_index(src.right_index),
        .edge_present(src.edge_present), .last_edge(src.last_edge),
        .cfg_we(cfg.valid), .cfg_data(cfg.left_count),
        .out_ready(dst.ready), .out_valid(dst.valid), .out_size(dst.matching_size),
        .stat(stat)
    );
endmodule
`default_nettype wire

// ----- sv/bmm_chk.sv -----
`default_nettype none
module bmm_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       src_valid,
    input wire logic       src_ready,
    input wire logic       dst_valid,
    input wire logic       dst_ready,
    input wire logic [6:0] dst_size,
    input wire logic       cfg_ready
);
    // an accepted edge blocks the next cycle (row read-modify-write)
    a_edge_gap: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !src_ready)
        else $error("edge accepted on consecutive cycles");

    // result never exceeds the vertex count
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> dst_size <= 7'd64)
        else $error("matching size out of range");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_size))
        else $error("result changed while stalled");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
endmodule

bind bipartite_max_matching_top bmm_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .src_valid(src.valid), .src_ready(src.ready),
    .dst_valid(dst.valid), .dst_ready(dst.ready), .dst_size(dst.matching_size),
    .cfg_ready(cfg.ready)
);
`default_nettype wire
